// ===== rtl/millisecond_software_timer_set_defines.svh =====
// assertion helpers shared by the timer set rtl
`ifndef MILLISECOND_SOFTWARE_TIMER_SET_DEFINES_SVH
`define MILLISECOND_SOFTWARE_TIMER_SET_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer set check failed");

// next-cycle implication, checked out of reset
`define MST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer set check failed");

`endif

// ===== rtl/mst_pkg.sv =====
package mst_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] TPS_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ONESHOT = 2'd1,
        OP_HOLD    = 2'd2,
        OP_TIMEOUT = 2'd3
    } t_op;

    typedef struct packed {
        t_op              operation;
        logic [CNT_W-1:0] duration;
    } t_in_item;

    typedef struct packed {
        logic second_pulse;
        logic oneshot_expired;
        logic hold_busy;
        logic timeout_expired;
    } t_out_item;

endpackage

// ===== rtl/mst_core.sv =====
`include "millisecond_software_timer_set_defines.svh"

module mst_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_fire,
    input  mst_pkg::t_in_item i_item,
    output mst_pkg::t_out_item o_result
);
    import mst_pkg::*;

    logic [CNT_W-1:0] r_tps;
    logic [CNT_W-1:0] r_hold_count, n_hold_count;
    logic [CNT_W-1:0] r_timeout_limit, n_timeout_limit;
    logic [CNT_W-1:0] r_timeout_elapsed, n_timeout_elapsed;
    logic             r_timeout_flag, n_timeout_flag;
    logic [CNT_W-1:0] r_oneshot_count, n_oneshot_count;
    logic             r_oneshot_flag, n_oneshot_flag;
    logic [CNT_W-1:0] r_second_divider, n_second_divider;
    logic [CNT_W:0]   w_div_inc;
    logic             w_pulse;

    // divider step widened so a full count never wraps before the compare
    assign w_div_inc = {1'b0, r_second_divider} + {{CNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_hold_count      = r_hold_count;
        n_timeout_limit   = r_timeout_limit;
        n_timeout_elapsed = r_timeout_elapsed;
        n_timeout_flag    = r_timeout_flag;
        n_oneshot_count   = r_oneshot_count;
        n_oneshot_flag    = r_oneshot_flag;
        n_second_divider  = r_second_divider;
        w_pulse           = 1'b0;
        case (i_item.operation)
            OP_TICK: begin
                if (r_hold_count != '0) begin
                    n_hold_count = r_hold_count - CNT_W'(1);
                end
                if (r_timeout_limit != '0) begin
                    if (r_timeout_elapsed >= r_timeout_limit) begin
                        n_timeout_flag = 1'b1;
                    end else begin
                        n_timeout_elapsed = r_timeout_elapsed + CNT_W'(1);
                    end
                end else begin
                    n_timeout_flag = 1'b0;
                end
                if (w_div_inc >= {1'b0, r_tps}) begin
                    w_pulse          = 1'b1;
                    n_second_divider = '0;
                end else begin
                    n_second_divider = w_div_inc[CNT_W-1:0];
                end
                if (r_oneshot_count != '0) begin
                    n_oneshot_count = r_oneshot_count - CNT_W'(1);
                    if (r_oneshot_count == {{(CNT_W-1){1'b0}}, 1'b1}) begin
                        n_oneshot_flag = 1'b1;
                    end
                end
            end
            OP_ONESHOT: begin
                n_oneshot_count = i_item.duration;
                n_oneshot_flag  = 1'b0;
            end
            OP_HOLD: begin
                n_hold_count = i_item.duration;
            end
            OP_TIMEOUT: begin
                n_timeout_limit   = i_item.duration;
                n_timeout_elapsed = '0;
                n_timeout_flag    = 1'b0;
            end
            default: begin
                n_hold_count = r_hold_count;
            end
        endcase
    end

    // result reflects state after the item
    always_comb begin
        o_result.second_pulse    = w_pulse;
        o_result.oneshot_expired = n_oneshot_flag;
        o_result.hold_busy       = (n_hold_count != '0);
        o_result.timeout_expired = n_timeout_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps             <= TPS_RESET;
            r_hold_count      <= '0;
            r_timeout_limit   <= '0;
            r_timeout_elapsed <= '0;
            r_timeout_flag    <= 1'b0;
            r_oneshot_count   <= '0;
            r_oneshot_flag    <= 1'b0;
            r_second_divider  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_hold_count      <= n_hold_count;
                r_timeout_limit   <= n_timeout_limit;
                r_timeout_elapsed <= n_timeout_elapsed;
                r_timeout_flag    <= n_timeout_flag;
                r_oneshot_count   <= n_oneshot_count;
                r_oneshot_flag    <= n_oneshot_flag;
                r_second_divider  <= n_second_divider;
            end
        end
    end

    `MST_ASSERT_NOW(a_cmd_no_pulse, i_fire && (i_item.operation != OP_TICK), !o_result.second_pulse)
    `MST_ASSERT_NEXT(a_pulse_restarts, i_fire && o_result.second_pulse, r_second_divider == '0)
    `MST_ASSERT_NEXT(a_idle_holds, !i_fire, $stable(r_hold_count) && $stable(r_oneshot_count))

endmodule

// ===== rtl/millisecond_software_timer_set.sv =====
// result path: input register, then result register
// throughput: one item per cycle while the result side is not stalled; the counter update
// for an item is a single pass through short compare/increment logic between the two registers
// a stalled result register holds its item while the input register still takes one more
// reset: synchronous, active low; all counters and flags clear, ticks_per_second reloads 1000
`include "millisecond_software_timer_set_defines.svh"

module millisecond_software_timer_set (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: ticks_per_second, written without handshake
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mst_pkg::t_in_item  i_in_item,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mst_pkg::t_out_item o_out_item
);
    import mst_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_item  r_in_item;
    // result register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_out_free;
    logic      w_fire;
    t_out_item w_result;

    // result register can take a new item when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // the buffered item is processed and committed to timer state
    assign w_fire     = r_in_valid && w_out_free;
    // input register frees up whenever its item moves on
    assign o_in_ready = !r_in_valid || w_fire;

    mst_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (r_in_item),
        .o_result    (w_result)
    );

    // input stage: payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `MST_ASSERT_NEXT(a_in_kept, r_in_valid && !w_fire, r_in_valid)
    `MST_ASSERT_NEXT(a_fire_to_out, w_fire, r_out_valid)
    `MST_ASSERT_NOW(a_empty_out_drains, r_in_valid && !r_out_valid, w_fire)

endmodule

// ===== verif/millisecond_software_timer_set_tb.sv =====
`timescale 1ns / 100ps

module millisecond_software_timer_set_tb;
    import mst_pkg::*;

    localparam int PHASE_ITEMS  = 250;   // random items per divider setting
    localparam int NUM_PHASES   = 8;
    localparam int SETTLE_DELAY = 4;     // two-stage pipe plus margin
    localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // shadow copy of the timer set, advanced once per accepted item
    logic [15:0] ticks_per_second_q = TPS_RESET;
    logic [15:0] hold_left          = '0;
    logic [15:0] timeout_limit_q    = '0;
    logic [15:0] timeout_elapsed_q  = '0;
    logic        timeout_flag_q     = 1'b0;
    logic [15:0] oneshot_left       = '0;
    logic        oneshot_flag_q     = 1'b0;
    logic [15:0] second_count       = '0;

    // status words still owed by the block, oldest first
    t_out_item expected_status_q[$];
    t_out_item oldest_status;

    // knobs for the random idle bursts on each side
    bit in_idle_en   = 1'b1;
    bit out_stall_en = 1'b1;
    int stall_left   = 0;

    int failures      = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int pulses_seen   = 0;
    int idle_cycles   = 0;

    millisecond_software_timer_set u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one item to the shadow state and return the status it should report
    function automatic t_out_item advance_timer_set(input t_in_item item);
        t_out_item   status;
        logic [16:0] next_count;
        status = '0;
        case (item.operation)
            OP_TICK: begin
                if (hold_left != 0)
                    hold_left = hold_left - 16'd1;
                // elapsed count stops at the limit, flag rises on the tick after
                if (timeout_limit_q != 0) begin
                    if (timeout_elapsed_q >= timeout_limit_q)
                        timeout_flag_q = 1'b1;
                    else
                        timeout_elapsed_q = timeout_elapsed_q + 16'd1;
                end else begin
                    timeout_flag_q = 1'b0;
                end
                // 17-bit compare so a full divider still wraps on a zero or lowered setting
                next_count = {1'b0, second_count} + 17'd1;
                if (next_count >= {1'b0, ticks_per_second_q}) begin
                    status.second_pulse = 1'b1;
                    second_count        = '0;
                end else begin
                    second_count = next_count[15:0];
                end
                if (oneshot_left != 0) begin
                    oneshot_left = oneshot_left - 16'd1;
                    if (oneshot_left == 0)
                        oneshot_flag_q = 1'b1;
                end
            end
            OP_ONESHOT: begin
                oneshot_left   = item.duration;
                oneshot_flag_q = 1'b0;
            end
            OP_HOLD: begin
                hold_left = item.duration;
            end
            OP_TIMEOUT: begin
                timeout_limit_q   = item.duration;
                timeout_elapsed_q = '0;
                timeout_flag_q    = 1'b0;
            end
            default: begin
            end
        endcase
        status.oneshot_expired = oneshot_flag_q;
        status.hold_busy       = (hold_left != 0);
        status.timeout_expired = timeout_flag_q;
        return status;
    endfunction

    function automatic void check_field(input string field, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", field, want, got);
            failures++;
        end
    endfunction

    // one item on the input channel; valid is left high on return so the next
    // call can follow back to back without a drop in between
    task automatic send_item(input t_op op, input logic [15:0] dur);
        t_in_item item;
        item.operation = op;
        item.duration  = dur;
        if (in_idle_en && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // transfer taken at this edge
        expected_status_q.push_back(advance_timer_set(item));
        items_sent++;
    endtask

    // sender holds off until every owed status word is back, then lets the pipe settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_DELAY) @(posedge i_clk);
    endtask

    // divider setting only changes with the block idle
    task automatic set_ticks_per_second(input logic [15:0] value);
        drain_results();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ticks_per_second_q = value;
    endtask

    // load commands and their corner values, divider at its reset setting
    task automatic test_timer_commands();
        send_item(OP_TICK, 16'hFFFF);      // duration is don't-care on a tick
        send_item(OP_ONESHOT, 16'h0000);   // zero load: one-shot stays idle, flag low
        send_item(OP_TICK, 16'h0000);
        send_item(OP_ONESHOT, 16'd1);
        send_item(OP_TICK, 16'h0000);      // one-shot expires here
        send_item(OP_HOLD, 16'hFFFF);
        send_item(OP_HOLD, 16'd1);
        send_item(OP_TICK, 16'h0000);      // hold drops to idle
        send_item(OP_TIMEOUT, 16'd2);
        repeat (3) send_item(OP_TICK, 16'h5A5A);  // flag on the tick after the limit
        send_item(OP_TIMEOUT, 16'h0000);   // rescheduling clears the flag
        send_item(OP_TICK, 16'h0000);      // zero limit keeps it clear
        send_item(OP_ONESHOT, 16'hFFFF);
        send_item(OP_TIMEOUT, 16'hFFFF);
    endtask

    // divider extremes, including a setting lowered below the running count
    task automatic test_second_divider();
        set_ticks_per_second(16'd0);       // every tick pulses
        repeat (2) send_item(OP_TICK, 16'h0000);
        set_ticks_per_second(16'd3);
        repeat (2) send_item(OP_TICK, 16'h0000);
        set_ticks_per_second(16'd1);       // count already past the new value
        send_item(OP_TICK, 16'h0000);
        set_ticks_per_second(16'hFFFF);
        send_item(OP_TICK, 16'h0000);
    endtask

    // mostly ticks with short loads so flags come and go, some long and noisy loads
    task automatic test_random_traffic();
        logic [15:0] tps_plan [NUM_PHASES];
        t_op         op;
        logic [15:0] dur;
        int          pick;
        tps_plan = '{16'd1, 16'd2, 16'd0, 16'd10, 16'd1000, 16'hFFFF, 16'd5, 16'd7};
        tps_plan[4] = 16'($urandom_range(3, 60));
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // last phase runs at full rate on both sides
            in_idle_en   = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            out_stall_en = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            set_ticks_per_second(tps_plan[phase]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    op  = OP_TICK;
                    dur = 16'($urandom);
                end else begin
                    op   = t_op'($urandom_range(1, 3));
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        dur = 16'($urandom_range(0, 30));
                    else if (pick < 85)
                        dur = 16'($urandom_range(0, 300));
                    else
                        dur = 16'($urandom);
                end
                // mid-phase pause with the counters running
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_item(op, dur);
            end
        end
    endtask

    // result side backpressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= (stall_left == 0);
        end else if (out_stall_en && $urandom_range(0, 9) == 0) begin
            stall_left  = $urandom_range(1, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // every result transfer is matched against the oldest owed status
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_status_q.size() == 0) begin
                $error("result transfer with nothing outstanding: %b", o_out_item);
                failures++;
            end else begin
                oldest_status = expected_status_q.pop_front();
                check_field("second_pulse", oldest_status.second_pulse,
                            o_out_item.second_pulse);
                check_field("oneshot_expired", oldest_status.oneshot_expired,
                            o_out_item.oneshot_expired);
                check_field("hold_busy", oldest_status.hold_busy, o_out_item.hold_busy);
                check_field("timeout_expired", oldest_status.timeout_expired,
                            o_out_item.timeout_expired);
            end
            results_seen++;
            if (o_out_item.second_pulse === 1'b1)
                pulses_seen++;
        end
    end

    // watchdog: too long without a transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_status_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_timer_commands();
        test_second_divider();
        test_random_traffic();

        drain_results();
        $display("%0d items, all four operations, %0d divider settings incl. 0, 1 and 65535",
                 items_sent, NUM_PHASES + 5);
        $display("%0d results checked, %0d second pulses seen", results_seen, pulses_seen);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
